// ----- hw/rtl/ivda_pkg.sv -----
// Shared types and constants of the int4 vector distance accumulator.
`default_nettype none
package ivda_pkg;

  localparam int WORD_W  = 64;
  localparam int WORD_BYTES = 8;
  localparam int VAL_W   = 8;
  localparam int PROD_W  = 16;
  localparam int ACC_W   = 64;
  localparam int MODE_W  = 2;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_DOT   = 2'd0,
    MODE_L2SQ  = 2'd1,
    MODE_NORMS = 2'd2
  } mode_e;

  localparam logic [CFG_IDX_W-1:0] CFG_METRIC_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NIBBLE_MASK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGN_PATTERN = 2'd2;

  localparam logic [WORD_W-1:0] NIBBLE_MASK_RST  = 64'h0F0F_0F0F_0F0F_0F0F;
  localparam logic [WORD_W-1:0] SIGN_PATTERN_RST = 64'h0808_0808_0808_0808;

  typedef struct packed {
    logic              valid;
    logic              last;
    logic [MODE_W-1:0] mode;
  } ctl_t;

endpackage
`default_nettype wire

// ----- hw/rtl/ivda_in_if.sv -----
// Input item channel: left and right packed words plus end-of-vector flag.
`default_nettype none
interface ivda_in_if;
  import ivda_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] left_word;
  logic [WORD_W-1:0] right_word;
  logic              last_word;

  modport source(output valid, left_word, right_word, last_word, input ready);
  modport sink(input valid, left_word, right_word, last_word, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/ivda_out_if.sv -----
// Result item channel: primary sum and the two norm sums.
`default_nettype none
interface ivda_out_if;
  import ivda_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [ACC_W-1:0] primary_sum;
  logic signed [ACC_W-1:0] left_norm_sum;
  logic signed [ACC_W-1:0] right_norm_sum;

  modport source(output valid, primary_sum, left_norm_sum, right_norm_sum, input ready);
  modport sink(input valid, primary_sum, left_norm_sum, right_norm_sum, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/ivda_product_stage.sv -----
// Nibble extraction, sign decode and per-lane products, registered.
`default_nettype none
module ivda_product_stage #(
  parameter int BYTES_PER_ITEM = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ivda_pkg::ctl_t                      ctl_i,
  input  logic [ivda_pkg::WORD_W-1:0]         left_i,
  input  logic [ivda_pkg::WORD_W-1:0]         right_i,
  input  logic [ivda_pkg::WORD_W-1:0]         nibble_mask_i,
  input  logic [ivda_pkg::WORD_W-1:0]         sign_pattern_i,
  output logic                                ready_o,
  input  logic                                ready_i,
  output ivda_pkg::ctl_t                      ctl_o,
  output logic signed [ivda_pkg::PROD_W-1:0]  prim_o [2*BYTES_PER_ITEM],
  output logic signed [ivda_pkg::PROD_W-1:0]  lsq_o  [2*BYTES_PER_ITEM],
  output logic signed [ivda_pkg::PROD_W-1:0]  rsq_o  [2*BYTES_PER_ITEM]
);
  import ivda_pkg::*;

  localparam int LANES = 2 * BYTES_PER_ITEM;

  function automatic logic [VAL_W-1:0] decode(input logic [VAL_W-1:0] v,
                                              input logic [VAL_W-1:0] m,
                                              input logic [VAL_W-1:0] s);
    decode = ((v & m) ^ s) - s;
  endfunction

  logic signed [VAL_W-1:0]  a_val [LANES];
  logic signed [VAL_W-1:0]  b_val [LANES];
  logic signed [PROD_W-1:0] prim_d [LANES];
  logic signed [PROD_W-1:0] lsq_d  [LANES];
  logic signed [PROD_W-1:0] rsq_d  [LANES];
  logic                     l2_mode;
  ctl_t                     ctl_q;

  assign l2_mode = (ctl_i.mode == MODE_L2SQ);

  for (genvar k = 0; k < BYTES_PER_ITEM; k++) begin : g_byte
    logic [VAL_W-1:0] lb, lup, rb, rup, mb, sb;

    assign mb = nibble_mask_i[VAL_W*(k % WORD_BYTES) +: VAL_W];
    assign sb = sign_pattern_i[VAL_W*(k % WORD_BYTES) +: VAL_W];

    if (k < WORD_BYTES) begin : g_in
      assign lb = left_i[VAL_W*k +: VAL_W];
      assign rb = right_i[VAL_W*k +: VAL_W];
    end else begin : g_out
      assign lb = '0;
      assign rb = '0;
    end

    if ((k % 2 == 0) && (k + 1 < BYTES_PER_ITEM) && (k + 1 < WORD_BYTES)) begin : g_up
      assign lup = left_i[VAL_W*(k+1) +: VAL_W];
      assign rup = right_i[VAL_W*(k+1) +: VAL_W];
    end else begin : g_noup
      assign lup = '0;
      assign rup = '0;
    end

    assign a_val[2*k]   = decode(lb, mb, sb);
    assign a_val[2*k+1] = decode({lup[3:0], lb[7:4]}, mb, sb);
    assign b_val[2*k]   = decode(rb, mb, sb);
    assign b_val[2*k+1] = decode({rup[3:0], rb[7:4]}, mb, sb);
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic signed [VAL_W-1:0] diff, x, y;

    assign diff     = a_val[i] - b_val[i];
    assign x        = l2_mode ? diff : a_val[i];
    assign y        = l2_mode ? diff : b_val[i];
    assign prim_d[i] = x * y;
    assign lsq_d[i]  = a_val[i] * a_val[i];
    assign rsq_d[i]  = b_val[i] * b_val[i];
  end

  assign ready_o = !ctl_q.valid || ready_i;
  assign ctl_o   = ctl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (ready_o) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && ctl_i.valid) begin
      prim_o <= prim_d;
      lsq_o  <= lsq_d;
      rsq_o  <= rsq_d;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/ivda_sum_stage.sv -----
// Adder trees over the lane products, registered.
`default_nettype none
module ivda_sum_stage #(
  parameter int BYTES_PER_ITEM = 8,
  parameter int SUM_W          = 21
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ivda_pkg::ctl_t                     ctl_i,
  input  logic signed [ivda_pkg::PROD_W-1:0] prim_i [2*BYTES_PER_ITEM],
  input  logic signed [ivda_pkg::PROD_W-1:0] lsq_i  [2*BYTES_PER_ITEM],
  input  logic signed [ivda_pkg::PROD_W-1:0] rsq_i  [2*BYTES_PER_ITEM],
  output logic                               ready_o,
  input  logic                               ready_i,
  output ivda_pkg::ctl_t                     ctl_o,
  output logic signed [SUM_W-1:0]            part_o,
  output logic signed [SUM_W-1:0]            lpart_o,
  output logic signed [SUM_W-1:0]            rpart_o
);
  import ivda_pkg::*;

  localparam int LANES = 2 * BYTES_PER_ITEM;
  localparam int LEAVES = 2 ** $clog2(LANES);

  logic signed [SUM_W-1:0] node_p [2*LEAVES-1];
  logic signed [SUM_W-1:0] node_l [2*LEAVES-1];
  logic signed [SUM_W-1:0] node_r [2*LEAVES-1];
  ctl_t                    ctl_q;

  for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
    if (i < LANES) begin : g_used
      assign node_p[LEAVES-1+i] = {{(SUM_W-PROD_W){prim_i[i][PROD_W-1]}}, prim_i[i]};
      assign node_l[LEAVES-1+i] = {{(SUM_W-PROD_W){lsq_i[i][PROD_W-1]}}, lsq_i[i]};
      assign node_r[LEAVES-1+i] = {{(SUM_W-PROD_W){rsq_i[i][PROD_W-1]}}, rsq_i[i]};
    end else begin : g_pad
      assign node_p[LEAVES-1+i] = '0;
      assign node_l[LEAVES-1+i] = '0;
      assign node_r[LEAVES-1+i] = '0;
    end
  end

  for (genvar i = 0; i < LEAVES - 1; i++) begin : g_node
    assign node_p[i] = node_p[2*i+1] + node_p[2*i+2];
    assign node_l[i] = node_l[2*i+1] + node_l[2*i+2];
    assign node_r[i] = node_r[2*i+1] + node_r[2*i+2];
  end

  assign ready_o = !ctl_q.valid || ready_i;
  assign ctl_o   = ctl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (ready_o) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && ctl_i.valid) begin
      part_o  <= node_p[0];
      lpart_o <= node_l[0];
      rpart_o <= node_r[0];
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/ivda_accumulator.sv -----
// 64-bit accumulators and the result register.
`default_nettype none
module ivda_accumulator #(
  parameter int SUM_W = 21
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ivda_pkg::ctl_t          ctl_i,
  input  logic signed [SUM_W-1:0] part_i,
  input  logic signed [SUM_W-1:0] lpart_i,
  input  logic signed [SUM_W-1:0] rpart_i,
  output logic                    ready_o,
  ivda_out_if.source              out_o
);
  import ivda_pkg::*;

  logic [ACC_W-1:0] prim_acc_q, prim_acc_d;
  logic [ACC_W-1:0] lnorm_acc_q, lnorm_acc_d;
  logic [ACC_W-1:0] rnorm_acc_q, rnorm_acc_d;
  logic [ACC_W-1:0] prim_sum, lnorm_sum, rnorm_sum;
  logic [ACC_W-1:0] prim_out_q, lnorm_out_q, rnorm_out_q;
  logic             out_valid_q, out_valid_d;
  logic             fire, norms_mode, emit;

  assign norms_mode = (ctl_i.mode == MODE_NORMS);
  assign ready_o    = !(ctl_i.last && out_valid_q && !out_o.ready);
  assign fire       = ctl_i.valid && ready_o;
  assign emit       = fire && ctl_i.last;

  assign prim_sum  = prim_acc_q + {{(ACC_W-SUM_W){part_i[SUM_W-1]}}, part_i};
  assign lnorm_sum = norms_mode ? lnorm_acc_q + {{(ACC_W-SUM_W){lpart_i[SUM_W-1]}}, lpart_i}
                                : lnorm_acc_q;
  assign rnorm_sum = norms_mode ? rnorm_acc_q + {{(ACC_W-SUM_W){rpart_i[SUM_W-1]}}, rpart_i}
                                : rnorm_acc_q;

  always_comb begin
    prim_acc_d  = prim_acc_q;
    lnorm_acc_d = lnorm_acc_q;
    rnorm_acc_d = rnorm_acc_q;
    out_valid_d = out_valid_q && !out_o.ready;
    if (fire) begin
      if (ctl_i.last) begin
        prim_acc_d  = '0;
        lnorm_acc_d = '0;
        rnorm_acc_d = '0;
        out_valid_d = 1'b1;
      end else begin
        prim_acc_d  = prim_sum;
        lnorm_acc_d = lnorm_sum;
        rnorm_acc_d = rnorm_sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prim_acc_q  <= '0;
      lnorm_acc_q <= '0;
      rnorm_acc_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      prim_acc_q  <= prim_acc_d;
      lnorm_acc_q <= lnorm_acc_d;
      rnorm_acc_q <= rnorm_acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      prim_out_q  <= prim_sum;
      lnorm_out_q <= norms_mode ? lnorm_sum : '0;
      rnorm_out_q <= norms_mode ? rnorm_sum : '0;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.primary_sum    = prim_out_q;
  assign out_o.left_norm_sum  = lnorm_out_q;
  assign out_o.right_norm_sum = rnorm_out_q;

endmodule
`default_nettype wire

// ----- hw/rtl/int4_vector_distance_accumulator.sv -----
// Top level: configuration registers, input register and the three pipeline stages.
// Accepts one item per clock: each item carries BYTES_PER_ITEM packed bytes of each vector,
// split into two 4-bit values per byte, sign-decoded, multiplied lane by lane and reduced
// into 64-bit wrapping accumulators. Items flow through an input register, a product
// register, an adder-tree register and the accumulator/result register, and a result
// appears once the item marked last_word has passed through them. The input
// stalls only when a last item reaches the accumulator while the previous result has not
// been taken; the items behind it then back up through the pipeline. metric_mode 0 gives
// the dot product, 1 the squared distance (8-bit wrapping difference), 2 the dot product
// with both squared norms; code 3 acts as 0.
// Change configuration only while no item is in flight.
`default_nettype none
module int4_vector_distance_accumulator #(
  parameter int BYTES_PER_ITEM = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [ivda_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [ivda_pkg::WORD_W-1:0]          cfg_wdata_i,
  ivda_in_if.sink                              in_i,
  ivda_out_if.source                           out_o
);
  import ivda_pkg::*;

  localparam int LANES = 2 * BYTES_PER_ITEM;
  localparam int SUM_W = PROD_W + $clog2(LANES) + 1;

  logic [MODE_W-1:0]       mode_q;
  logic [WORD_W-1:0]       nibble_mask_q;
  logic [WORD_W-1:0]       sign_pattern_q;

  ctl_t                    s1_ctl_q, s1_ctl_d;
  logic [WORD_W-1:0]       s1_left_q, s1_right_q;
  logic                    in_fire;

  ctl_t                    s2_ctl, s3_ctl;
  logic                    prod_ready, sum_ready, acc_ready;
  logic signed [PROD_W-1:0] prim [LANES];
  logic signed [PROD_W-1:0] lsq  [LANES];
  logic signed [PROD_W-1:0] rsq  [LANES];
  logic signed [SUM_W-1:0] part, lpart, rpart;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= MODE_DOT;
      nibble_mask_q  <= NIBBLE_MASK_RST;
      sign_pattern_q <= SIGN_PATTERN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_METRIC_MODE:  mode_q         <= cfg_wdata_i[MODE_W-1:0];
        CFG_NIBBLE_MASK:  nibble_mask_q  <= cfg_wdata_i;
        CFG_SIGN_PATTERN: sign_pattern_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_i.ready = !s1_ctl_q.valid || prod_ready;
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    s1_ctl_d = s1_ctl_q;
    if (in_fire) begin
      s1_ctl_d.valid = 1'b1;
      s1_ctl_d.last  = in_i.last_word;
      s1_ctl_d.mode  = mode_q;
    end else if (prod_ready) begin
      s1_ctl_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q <= '0;
    end else begin
      s1_ctl_q <= s1_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_left_q  <= in_i.left_word;
      s1_right_q <= in_i.right_word;
    end
  end

  ivda_product_stage #(
    .BYTES_PER_ITEM(BYTES_PER_ITEM)
  ) u_product (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (s1_ctl_q),
    .left_i         (s1_left_q),
    .right_i        (s1_right_q),
    .nibble_mask_i  (nibble_mask_q),
    .sign_pattern_i (sign_pattern_q),
    .ready_o        (prod_ready),
    .ready_i        (sum_ready),
    .ctl_o          (s2_ctl),
    .prim_o         (prim),
    .lsq_o          (lsq),
    .rsq_o          (rsq)
  );

  ivda_sum_stage #(
    .BYTES_PER_ITEM(BYTES_PER_ITEM),
    .SUM_W         (SUM_W)
  ) u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (s2_ctl),
    .prim_i  (prim),
    .lsq_i   (lsq),
    .rsq_i   (rsq),
    .ready_o (sum_ready),
    .ready_i (acc_ready),
    .ctl_o   (s3_ctl),
    .part_o  (part),
    .lpart_o (lpart),
    .rpart_o (rpart)
  );

  ivda_accumulator #(
    .SUM_W(SUM_W)
  ) u_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (s3_ctl),
    .part_i  (part),
    .lpart_i (lpart),
    .rpart_i (rpart),
    .ready_o (acc_ready),
    .out_o   (out_o)
  );

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(s3_ctl.valid && s3_ctl.last && acc_ready))
    else $error("result raised without a last item");

  a_norms_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_ctl.valid && s3_ctl.last && acc_ready && (s3_ctl.mode != MODE_NORMS))
    |=> (out_o.left_norm_sum == '0) && (out_o.right_norm_sum == '0))
    else $error("norm sums nonzero outside norm mode");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_ctl_q.valid && !prod_ready) |=> (s1_ctl_q.valid && $stable(s1_left_q)))
    else $error("input register lost a stalled item");

endmodule
`default_nettype wire
